[src/mmpd_pkg.sv]
// ----------------------------------------------------------------------------
// mmpd_pkg
// Shared types and constants of the min/max point decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpd_pkg;

    localparam int ADDR_W = 3;
    localparam int FS_W = 31;
    localparam logic [FS_W-1:0] FS_RESET = 31'd65536;
    localparam logic REG_FILTER_SIZE = 1'b0;

    typedef struct packed {
        logic has_pair;
        logic has_tail;
    } job_ctl_t;

    typedef enum logic [2:0] {
        PH_A = 3'b001,
        PH_B = 3'b010,
        PH_T = 3'b100
    } phase_t;

endpackage

`default_nettype wire

[src/mmpd_front.sv]
// ----------------------------------------------------------------------------
// mmpd_front
// Accepts points, tracks the open bucket, issues jobs for points with output.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpd_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  [mmpd_pkg::FS_W-1:0]         filter_size,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  signed [COORD_WIDTH-1:0]     in_x,
    input  wire  signed [COORD_WIDTH-1:0]     in_y,
    input  wire                               in_last,
    input  wire                               queue_full,
    output logic                              push,
    output mmpd_pkg::job_ctl_t                job_ctl,
    output logic [COORD_WIDTH-1:0]            job_bx,
    output logic [COORD_WIDTH-1:0]            job_a,
    output logic [COORD_WIDTH-1:0]            job_b,
    output logic [COORD_WIDTH-1:0]            job_tx,
    output logic [COORD_WIDTH-1:0]            job_ty
);

    localparam int DW = (COORD_WIDTH + 1 > mmpd_pkg::FS_W) ? COORD_WIDTH + 1 : mmpd_pkg::FS_W;

    logic                          started_reg, started_next;
    logic signed [COORD_WIDTH-1:0] bucket_x_reg, bucket_x_next;
    logic signed [COORD_WIDTH-1:0] first_y_reg, first_y_next;
    logic signed [COORD_WIDTH-1:0] min_y_reg, min_y_next;
    logic signed [COORD_WIDTH-1:0] max_y_reg, max_y_next;

    logic                          accept;
    logic signed [COORD_WIDTH:0]   diff;
    logic signed [DW-1:0]          diff_ext;
    logic [DW-1:0]                 fs_ext;
    logic                          close;
    logic                          rising;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign diff     = (COORD_WIDTH+1)'(in_x) - (COORD_WIDTH+1)'(bucket_x_reg);
    assign diff_ext = DW'(diff);
    assign fs_ext   = DW'(filter_size);
    assign close    = started_reg && !diff[COORD_WIDTH] && ($unsigned(diff_ext) >= fs_ext);
    assign rising   = in_y > first_y_reg;

    always_comb
    begin
        job_ctl.has_pair = close;
        job_ctl.has_tail = !started_reg || in_last;
        push             = accept && (job_ctl.has_pair || job_ctl.has_tail);
        job_bx           = bucket_x_reg;
        job_a            = rising ? min_y_reg : max_y_reg;
        job_b            = rising ? max_y_reg : min_y_reg;
        job_tx           = in_x;
        job_ty           = in_y;
    end

    always_comb
    begin
        started_next  = started_reg;
        bucket_x_next = bucket_x_reg;
        first_y_next  = first_y_reg;
        min_y_next    = min_y_reg;
        max_y_next    = max_y_reg;
        if (accept)
        begin
            started_next = !in_last;
            if (!started_reg || close)
            begin
                bucket_x_next = in_x;
                first_y_next  = in_y;
                min_y_next    = in_y;
                max_y_next    = in_y;
            end
            else
            begin
                if (in_y < min_y_reg)
                    min_y_next = in_y;
                if (in_y > max_y_reg)
                    max_y_next = in_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            bucket_x_reg <= '0;
            first_y_reg  <= '0;
            min_y_reg    <= '0;
            max_y_reg    <= '0;
        end
        else
        begin
            started_reg  <= started_next;
            bucket_x_reg <= bucket_x_next;
            first_y_reg  <= first_y_next;
            min_y_reg    <= min_y_next;
            max_y_reg    <= max_y_next;
        end
    end

    a_last_ends_series: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> !started_reg)
        else $error("series still open after last point");

    a_bucket_order: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (min_y_reg <= first_y_reg) && (first_y_reg <= max_y_reg))
        else $error("bucket min/first/max out of order");

endmodule

`default_nettype wire

[src/mmpd_queue.sv]
// ----------------------------------------------------------------------------
// mmpd_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpd_queue #(
    parameter int DATA_W = 162
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire  [DATA_W-1:0] wdata,
    output logic              full,
    input  wire               pop,
    output logic              valid,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/mmpd_back.sv]
// ----------------------------------------------------------------------------
// mmpd_back
// Expands queued jobs into emitted points in an output register, one per
// cycle while a job is queued and out_ready does not stall the register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpd_back #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         job_valid,
    output logic                        job_pop,
    input  mmpd_pkg::job_ctl_t          job_ctl,
    input  wire  [COORD_WIDTH-1:0]      job_bx,
    input  wire  [COORD_WIDTH-1:0]      job_a,
    input  wire  [COORD_WIDTH-1:0]      job_b,
    input  wire  [COORD_WIDTH-1:0]      job_tx,
    input  wire  [COORD_WIDTH-1:0]      job_ty,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [COORD_WIDTH-1:0]      out_x,
    output logic [COORD_WIDTH-1:0]      out_y,
    output logic                        out_last
);

    mmpd_pkg::phase_t          phase_reg, phase_next;
    logic                      valid_reg, valid_next;
    logic [COORD_WIDTH-1:0]    x_reg, x_next;
    logic [COORD_WIDTH-1:0]    y_reg, y_next;
    logic                      last_reg, last_next;
    logic                      advance;

    assign advance   = job_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        phase_next = phase_reg;
        job_pop    = 1'b0;
        valid_next = valid_reg && !out_ready;
        x_next     = x_reg;
        y_next     = y_reg;
        last_next  = last_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            unique case (phase_reg)
                mmpd_pkg::PH_B:
                begin
                    x_next    = job_bx;
                    y_next    = job_b;
                    last_next = !job_ctl.has_tail;
                    if (job_ctl.has_tail)
                        phase_next = mmpd_pkg::PH_T;
                    else
                    begin
                        phase_next = mmpd_pkg::PH_A;
                        job_pop    = 1'b1;
                    end
                end
                mmpd_pkg::PH_T:
                begin
                    x_next     = job_tx;
                    y_next     = job_ty;
                    last_next  = 1'b1;
                    phase_next = mmpd_pkg::PH_A;
                    job_pop    = 1'b1;
                end
                default:
                begin
                    if (job_ctl.has_pair)
                    begin
                        x_next     = job_bx;
                        y_next     = job_a;
                        last_next  = 1'b0;
                        phase_next = mmpd_pkg::PH_B;
                    end
                    else
                    begin
                        x_next     = job_tx;
                        y_next     = job_ty;
                        last_next  = 1'b1;
                        phase_next = mmpd_pkg::PH_A;
                        job_pop    = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mmpd_pkg::PH_A;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        last_reg <= last_next;
    end

    a_mid_job_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != mmpd_pkg::PH_A |-> job_valid)
        else $error("mid-job phase without a queued job");

    a_tail_phase_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mmpd_pkg::PH_T |-> job_ctl.has_pair && job_ctl.has_tail)
        else $error("tail phase on a job without pair and tail");

endmodule

`default_nettype wire

[src/min_max_point_decimator_core.sv]
// ----------------------------------------------------------------------------
// min_max_point_decimator_core
// Min/max decimation of a stream of (x, y) points for plotting.
// ----------------------------------------------------------------------------
// Each point is accepted while the two-entry job queue has room; a point yields
// zero to three output points, and the back end sends one output point per cycle
// from its output register unless m_tready stalls it. A point that closes a
// bucket yields two output points (three with end of series); points that close
// no bucket are accepted one per cycle while the queue has room, also while the
// back end expands jobs that wait in the queue ahead of the output register.
`default_nettype none

module min_max_point_decimator_core #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // APB configuration
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [mmpd_pkg::ADDR_W-1:0]         paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input points
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,   // point_x, point_y
    input  wire                                 s_tlast,   // end_of_series
    // output points
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,   // out_x, out_y
    output logic                                m_tlast    // run_last
);

    localparam int TDATA_W = ((2*COORD_WIDTH+7)/8)*8;
    localparam int JOB_W   = $bits(mmpd_pkg::job_ctl_t) + 5*COORD_WIDTH;

    logic [mmpd_pkg::FS_W-1:0]  filter_size_reg, filter_size_next;
    logic                       cfg_wr;

    logic                       q_push, q_full, q_pop, q_valid;
    mmpd_pkg::job_ctl_t         f_ctl, b_ctl;
    logic [COORD_WIDTH-1:0]     f_bx, f_a, f_b, f_tx, f_ty;
    logic [COORD_WIDTH-1:0]     b_bx, b_a, b_b, b_tx, b_ty;
    logic [JOB_W-1:0]           q_wdata, q_rdata;
    logic [COORD_WIDTH-1:0]     o_x, o_y;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == mmpd_pkg::REG_FILTER_SIZE);

    always_comb
    begin
        filter_size_next = filter_size_reg;
        if (cfg_wr)
            filter_size_next = pwdata[mmpd_pkg::FS_W-1:0];
        if (paddr[2] == mmpd_pkg::REG_FILTER_SIZE)
            prdata = 32'(filter_size_reg);
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filter_size_reg <= mmpd_pkg::FS_RESET;
        else
            filter_size_reg <= filter_size_next;
    end

    mmpd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_size (filter_size_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_x        (s_tdata[COORD_WIDTH-1:0]),
        .in_y        (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_last     (s_tlast),
        .queue_full  (q_full),
        .push        (q_push),
        .job_ctl     (f_ctl),
        .job_bx      (f_bx),
        .job_a       (f_a),
        .job_b       (f_b),
        .job_tx      (f_tx),
        .job_ty      (f_ty)
    );

    assign q_wdata = {f_ctl, f_bx, f_a, f_b, f_tx, f_ty};

    mmpd_queue #(.DATA_W(JOB_W)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    assign {b_ctl, b_bx, b_a, b_b, b_tx, b_ty} = q_rdata;

    mmpd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .job_ctl   (b_ctl),
        .job_bx    (b_bx),
        .job_a     (b_a),
        .job_b     (b_b),
        .job_tx    (b_tx),
        .job_ty    (b_ty),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (o_x),
        .out_y     (o_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = TDATA_W'({o_y, o_x});

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min/max point decimator core. A directed table
// walks the coordinate extremes, bucket closing in both orders, one-point and
// three-result series, decreasing x and the filter_size edge values, then
// random series run under three idling patterns and several filter settings.
// Every output point is checked against an in-bench decimation model or a value given in the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W = mmpd_pkg::ADDR_W;
    localparam int FS_W = mmpd_pkg::FS_W;
    localparam int CW = 32;
    localparam int TDATA_W = ((2 * CW + 7) / 8) * 8;
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [ADDR_W-1:0] ADDR_FILTER_SIZE = {mmpd_pkg::REG_FILTER_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE = {~mmpd_pkg::REG_FILTER_SIZE, 2'b00};
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SEGMENT_POINTS = 70;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } point_t;

    typedef enum logic {
        STEP_POINT,
        STEP_WRITE
    } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic                eos;
        logic [ADDR_W-1:0]   addr;
        logic [31:0]         wdata;
        logic                known;
        point_t              want;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;   // point_x, point_y
    logic                s_tlast = 1'b0; // end_of_series
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;        // out_x, out_y
    logic                m_tlast;        // run_last

    // decimation model state
    logic                in_series = 1'b0;
    logic signed [CW-1:0] bkt_x = '0;
    logic signed [CW-1:0] bkt_first_y = '0;
    logic signed [CW-1:0] bkt_min_y = '0;
    logic signed [CW-1:0] bkt_max_y = '0;
    logic [FS_W-1:0]     fsize = mmpd_pkg::FS_RESET;

    point_t              fresh_pts [3];
    point_t              pending_pts [$];

    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatches = 0;
    int                  points_sent = 0;
    int                  series_done = 0;
    int                  bucket_closes = 0;
    int                  results_seen = 0;
    int                  filter_writes = 0;
    int                  cycle_count = 0;

    min_max_point_decimator_core #(
        .COORD_WIDTH (CW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, pending_pts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endfunction

    // Returns the number of output points one input point causes.
    function automatic int decimate(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                    logic eos);
        logic [CW:0] dx;
        logic        close_bkt;
        logic        rising;
        int          n;
        n = 0;
        if (!in_series)
        begin
            fresh_pts[0] = '{x: px, y: py, last: 1'b1};
            bkt_x = px;
            bkt_first_y = py;
            bkt_min_y = py;
            bkt_max_y = py;
            in_series = !eos;
            if (eos)
                series_done++;
            return 1;
        end
        dx = {px[CW-1], px} - {bkt_x[CW-1], bkt_x};
        close_bkt = !dx[CW] && (dx[CW-1:0] >= CW'(fsize));
        if (close_bkt)
        begin
            rising = py > bkt_first_y;
            fresh_pts[0] = '{x: bkt_x, y: rising ? bkt_min_y : bkt_max_y, last: 1'b0};
            fresh_pts[1] = '{x: bkt_x, y: rising ? bkt_max_y : bkt_min_y, last: !eos};
            n = 2;
            bucket_closes++;
            bkt_x = px;
            bkt_first_y = py;
            bkt_min_y = py;
            bkt_max_y = py;
        end
        else
        begin
            if (py < bkt_min_y)
                bkt_min_y = py;
            if (py > bkt_max_y)
                bkt_max_y = py;
        end
        if (eos)
        begin
            fresh_pts[n] = '{x: px, y: py, last: 1'b1};
            n = n + 1;
            in_series = 1'b0;
            series_done++;
        end
        return n;
    endfunction

    always @(posedge clk)
    begin : out_check
        point_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pts.size() == 0)
                note_mismatch("unexpected output point", '0, 64'(m_tdata));
            else
            begin
                e = pending_pts.pop_front();
                results_seen++;
                if (m_tdata[CW-1:0] !== e.x)
                    note_mismatch("out_x", 64'(e.x), 64'(m_tdata[CW-1:0]));
                if (m_tdata[2*CW-1:CW] !== e.y)
                    note_mismatch("out_y", 64'(e.y), 64'(m_tdata[2*CW-1:CW]));
                if (m_tlast !== e.last)
                    note_mismatch("run_last", 64'(e.last), 64'(m_tlast));
            end
        end
    end

    task automatic accept_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                input logic eos, input logic known, input point_t want);
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= TDATA_W'({py, px});
        s_tlast <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        points_sent++;
        n = decimate(px, py, eos);
        if (known)
            pending_pts.push_back(want);
        else
            for (int i = 0; i < n; i++)
                pending_pts.push_back(fresh_pts[i]);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        logic [31:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[ADDR_W-1:2] == mmpd_pkg::REG_FILTER_SIZE)
            fsize = data[FS_W-1:0];
        filter_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_FILTER_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(fsize))
            note_mismatch("filter_size readback", 64'(fsize), 64'(rd));
    endtask

    function automatic step_t pt(logic [CW-1:0] x, logic [CW-1:0] y, logic eos);
        step_t s;
        s.kind = STEP_POINT;
        s.x = x;
        s.y = y;
        s.eos = eos;
        s.addr = '0;
        s.wdata = '0;
        s.known = 1'b0;
        s.want = '0;
        return s;
    endfunction

    // point whose only output point is known up front
    function automatic step_t pt_known(logic [CW-1:0] x, logic [CW-1:0] y, logic eos,
                                       logic [CW-1:0] wx, logic [CW-1:0] wy, logic wlast);
        step_t s;
        s = pt(x, y, eos);
        s.known = 1'b1;
        s.want = '{x: wx, y: wy, last: wlast};
        return s;
    endfunction

    function automatic step_t wr(logic [ADDR_W-1:0] addr, logic [31:0] data);
        step_t s;
        s = pt('0, '0, 1'b0);
        s.kind = STEP_WRITE;
        s.addr = addr;
        s.wdata = data;
        return s;
    endfunction

    function automatic logic [31:0] pick_filter();
        logic [FS_W-1:0] fs;
        case ($urandom_range(4))
            0: fs = '0;
            1: fs = FS_W'($urandom_range(1, 16));
            2: fs = mmpd_pkg::FS_RESET;
            3: fs = FS_W'($urandom);
            default: fs = FS_W'($urandom_range(0, 'h100000));
        endcase
        return {1'($urandom_range(1)), fs};
    endfunction

    task automatic run_segment(input int n_points);
        int            sent;
        int            len;
        longint        nx;
        longint        step;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          eos;
        sent = 0;
        while (sent < n_points)
        begin
            len = $urandom_range(1, 12);
            if ($urandom_range(1))
                x = CW'($urandom);
            else
                x = CW'($urandom_range(0, 'h40000)) - CW'('h20000);
            for (int i = 0; i < len && sent < n_points; i++)
            begin
                if ($urandom_range(3) == 0)
                    y = CW'($urandom_range(0, 6)) - CW'(3);
                else
                    y = CW'($urandom);
                eos = (i == len - 1);
                if ($urandom_range(99) < 8)
                begin
                    x = CW'($urandom);
                    eos = 1'($urandom_range(1));
                end
                accept_point(x, y, eos, 1'b0, '0);
                sent++;
                case ($urandom_range(9))
                    0, 1: step = 0;
                    2, 3: step = $urandom_range(0, fsize);
                    4: step = fsize;
                    5, 6: step = longint'(fsize) + $urandom_range(0, 'h20000);
                    7: step = longint'($urandom);
                    default: step = $urandom_range(1, 'h30000);
                endcase
                nx = longint'($signed(x)) + step;
                if (nx > COORD_MAX)
                    nx = COORD_MAX;
                x = nx[CW-1:0];
            end
        end
    endtask

    initial
    begin : stimulus
        step_t plan [$];
        int    send_plan [3];
        int    recv_plan [3];
        send_plan = '{26, 73, 0};
        recv_plan = '{73, 26, 0};

        plan.push_back(pt_known(MINC, MAXC, 1'b1, MINC, MAXC, 1'b1));
        plan.push_back(pt_known(MINC, MINC, 1'b0, MINC, MINC, 1'b1));
        plan.push_back(pt(32'h8000_8000, 32'd5, 1'b0));
        plan.push_back(pt(32'h8001_0000, MAXC, 1'b0));
        plan.push_back(pt(32'h8001_0000, MINC, 1'b0));
        plan.push_back(pt(MAXC, MINC, 1'b0));
        plan.push_back(pt(32'h7FFF_FFFE, 32'd7, 1'b0));
        plan.push_back(pt(MAXC, 32'd3, 1'b1));
        plan.push_back(wr(ADDR_SPARE, 32'h0001_2345));
        plan.push_back(wr(ADDR_FILTER_SIZE, 32'h0000_0000));
        plan.push_back(pt_known(32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1));
        plan.push_back(pt(32'd0, 32'd0, 1'b0));
        plan.push_back(pt(32'hFFFF_FFFF, 32'd9, 1'b0));
        plan.push_back(pt(32'd0, 32'd9, 1'b1));
        plan.push_back(wr(ADDR_FILTER_SIZE, 32'hFFFF_FFFF));
        plan.push_back(pt_known(MINC, 32'd1, 1'b0, MINC, 32'd1, 1'b1));
        plan.push_back(pt(32'hFFFF_FFFE, 32'd2, 1'b0));
        plan.push_back(pt(32'hFFFF_FFFF, 32'd0, 1'b0));
        plan.push_back(pt(MAXC, 32'hFFFF_FFFB, 1'b1));
        plan.push_back(wr(ADDR_FILTER_SIZE, 32'h8000_0005));
        plan.push_back(pt_known(32'd10, 32'hFFFF_FFFF, 1'b0, 32'd10, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(pt(32'd14, 32'd1, 1'b0));
        plan.push_back(pt(32'd15, 32'hFFFF_FFFF, 1'b1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = send_plan[0];
        recv_idle_pct = recv_plan[0];
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_WRITE)
            begin
                settle();
                apb_write(plan[i].addr, plan[i].wdata);
            end
            else
                accept_point(plan[i].x, plan[i].y, plan[i].eos, plan[i].known, plan[i].want);
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = send_plan[p];
            recv_idle_pct = recv_plan[p];
            for (int seg = 0; seg < 2; seg++)
            begin
                settle();
                apb_write(ADDR_FILTER_SIZE, pick_filter());
                run_segment(SEGMENT_POINTS);
            end
        end

        settle();
        $display("Sent %0d points (%0d series ended) across %0d register writes;",
                 points_sent, series_done, filter_writes);
        $display("%0d bucket closes, %0d output points checked, %0d mismatches.",
                 bucket_closes, results_seen, mismatches);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
